// File: rtl/core/tsv_pkg.sv
`default_nettype none
// Shared types and constants for the type stack verifier
package tsv_pkg;

	// Op codes; codes 13 to 15 are invalid
	typedef enum logic [3:0] {
		OP_NOP     = 4'd0,
		OP_END     = 4'd1,
		OP_I8      = 4'd2,
		OP_I16     = 4'd3,
		OP_I32     = 4'd4,
		OP_PTR     = 4'd5,
		OP_I64     = 4'd6,
		OP_ADDR    = 4'd7,
		OP_DBADDR  = 4'd8,
		OP_LD      = 4'd9,
		OP_STR     = 4'd10,
		OP_SYS     = 4'd11,
		OP_BUILTIN = 4'd12
	} opcode_t;

	// Status codes reported with each result
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_OPCODE  = 3'd1,
		ST_TOO_LARGE   = 3'd2,
		ST_RANGE       = 3'd3,
		ST_UNDERFLOW   = 3'd4,
		ST_BAD_SYS     = 3'd5,
		ST_BAD_BUILTIN = 3'd6,
		ST_NO_MEM      = 3'd7
	} status_t;

	localparam logic [2:0]  KIND_PTR      = 3'd3;
	localparam logic [2:0]  KIND_VOID     = 3'd5;
	localparam logic [63:0] OPERAND_LIMIT = 64'hFFFF_FFFF;
	localparam logic [63:0] SYS_COUNT     = 64'd3;
	localparam logic [63:0] SYS_EXIT      = 64'd0;
	localparam logic [63:0] BUILTIN_COUNT = 64'd4;

	// Items each op needs on the stack
	localparam logic [1:0]  NEED_LD       = 2'd1;
	localparam logic [1:0]  NEED_STR      = 2'd2;
	localparam logic [1:0]  NEED_EXIT     = 2'd1;
	localparam logic [1:0]  NEED_RW       = 2'd3;

	// One stack entry: element kind and element count
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] count;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// Control from the op decoder to the state registers
	typedef struct packed {
		logic       set_err;
		status_t    err_code;
		logic [1:0] err_exp;
		logic       underflow;
		logic       wr_en;
		logic       top_from_mem;
		slot_t      new_top;
	} step_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/tsv_ram.sv
`default_nettype none
// Generic single write, single read RAM with registered read data
module tsv_ram #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// File: rtl/core/tsv_step.sv
`default_nettype none
// Decodes one op against the current depth and works out the stack update
module tsv_step
	import tsv_pkg::*;
#(
	parameter int STACK_DEPTH = 64,
	parameter int DEPTH_W     = 7
) (
	input  wire logic               valid,
	input  wire logic [3:0]         opcode,
	input  wire logic [63:0]        operand,
	input  wire logic [2:0]         load_kind,
	input  wire logic [31:0]        load_count,
	input  wire logic [DEPTH_W-1:0] depth,
	input  wire status_t            sticky,
	input  wire logic [15:0]        db_count,
	output      step_ctl_t          ctl,
	output      logic [DEPTH_W-1:0] depth_next
);

	logic       do_push;
	logic [2:0] push_kind;
	logic       full;
	logic       too_large;
	logic [2:0] ld_kind;

	assign full      = (depth == DEPTH_W'(STACK_DEPTH));
	assign too_large = (operand >= OPERAND_LIMIT);
	assign ld_kind   = (load_kind > KIND_VOID) ? KIND_VOID : load_kind;

	always_comb begin
		ctl          = '0;
		ctl.err_code = ST_OK;
		depth_next   = depth;
		do_push      = 1'b0;
		push_kind    = KIND_PTR;

		if (valid && sticky == ST_OK) begin
			unique case (opcode)
				OP_NOP: begin
				end
				OP_END: begin
					depth_next = '0;
				end
				OP_I8, OP_I16, OP_I32, OP_PTR, OP_I64: begin
					do_push   = 1'b1;
					push_kind = 3'(opcode - 4'(OP_I8));
				end
				OP_ADDR: begin
					// index zero always passes the range check, else it must lie below the depth
					if (too_large) begin
						ctl.set_err  = 1'b1;
						ctl.err_code = ST_TOO_LARGE;
					end else if (operand != '0 && operand >= 64'(depth)) begin
						ctl.set_err  = 1'b1;
						ctl.err_code = ST_RANGE;
					end else begin
						do_push = 1'b1;
					end
				end
				OP_DBADDR: begin
					if (too_large) begin
						ctl.set_err  = 1'b1;
						ctl.err_code = ST_TOO_LARGE;
					end else if (operand >= 64'(db_count)) begin
						ctl.set_err  = 1'b1;
						ctl.err_code = ST_RANGE;
					end else begin
						do_push = 1'b1;
					end
				end
				OP_LD: begin
					if (depth < DEPTH_W'(NEED_LD)) begin
						ctl.set_err   = 1'b1;
						ctl.err_code  = ST_UNDERFLOW;
						ctl.err_exp   = NEED_LD;
						ctl.underflow = 1'b1;
					end else begin
						ctl.wr_en   = 1'b1;
						ctl.new_top = '{kind: ld_kind, count: load_count};
					end
				end
				OP_STR: begin
					if (depth < DEPTH_W'(NEED_STR)) begin
						ctl.set_err   = 1'b1;
						ctl.err_code  = ST_UNDERFLOW;
						ctl.err_exp   = NEED_STR;
						ctl.underflow = 1'b1;
					end else begin
						depth_next       = depth - DEPTH_W'(NEED_STR);
						ctl.top_from_mem = 1'b1;
					end
				end
				OP_SYS: begin
					// id check comes before the depth check
					if (operand >= SYS_COUNT) begin
						ctl.set_err  = 1'b1;
						ctl.err_code = ST_BAD_SYS;
					end else if (operand == SYS_EXIT) begin
						if (depth < DEPTH_W'(NEED_EXIT)) begin
							ctl.set_err   = 1'b1;
							ctl.err_code  = ST_UNDERFLOW;
							ctl.err_exp   = NEED_EXIT;
							ctl.underflow = 1'b1;
						end else begin
							depth_next = '0;
						end
					end else begin
						// write and read: three items become one ptr
						if (depth < DEPTH_W'(NEED_RW)) begin
							ctl.set_err   = 1'b1;
							ctl.err_code  = ST_UNDERFLOW;
							ctl.err_exp   = NEED_RW;
							ctl.underflow = 1'b1;
						end else begin
							depth_next  = depth - DEPTH_W'(NEED_RW) + DEPTH_W'(1);
							ctl.wr_en   = 1'b1;
							ctl.new_top = '{kind: KIND_PTR, count: 32'd1};
						end
					end
				end
				OP_BUILTIN: begin
					if (operand >= BUILTIN_COUNT) begin
						ctl.set_err  = 1'b1;
						ctl.err_code = ST_BAD_BUILTIN;
					end else begin
						do_push = 1'b1;
					end
				end
				default: begin
					ctl.set_err  = 1'b1;
					ctl.err_code = ST_BAD_OPCODE;
				end
			endcase

			// common push path
			if (do_push) begin
				if (full) begin
					ctl.set_err  = 1'b1;
					ctl.err_code = ST_NO_MEM;
				end else begin
					depth_next  = depth + DEPTH_W'(1);
					ctl.wr_en   = 1'b1;
					ctl.new_top = '{kind: push_kind, count: 32'd1};
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/bytecode_type_stack_verifier_top.sv
`default_nettype none
// Type stack verifier for the bytecode of one procedure. Ops are issued with
// start and are taken in every cycle (busy never rises); each op gives one
// result word via the input and result registers, shown for one cycle with
// done, and the receiver cannot stall it. Throughput is one op per clock, set
// by the top-of-stack register and a RAM read port that keeps the entry two
// below the top prefetched, so a pop of two finds its new top ready. The first
// error is sticky: later ops are ignored and the error is repeated until reset.
// The user must write data_block_count over the cfg channel only while no op is
// in flight (not enforced here); no clearing pass is needed after reset.
module bytecode_type_stack_verifier_top
	import tsv_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output      logic                               busy,
	input  wire logic [3:0]                         opcode,
	input  wire logic [63:0]                        operand,
	input  wire logic [2:0]                         load_kind,
	input  wire logic [31:0]                        load_count,
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic [15:0]                        cfg_data,
	output      logic                               done,
	output      logic [2:0]                         status,
	output      logic [1:0]                         expected_depth,
	output      logic [$clog2(STACK_DEPTH+1)-1:0]   actual_depth,
	output      logic [$clog2(STACK_DEPTH+1)-1:0]   depth_after,
	output      logic [2:0]                         top_kind,
	output      logic [31:0]                        top_count
);

	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W  = $clog2(STACK_DEPTH);

	// input register
	logic               valid_s1;
	logic [3:0]         opcode_s1;
	logic [63:0]        operand_s1;
	logic [2:0]         load_kind_s1;
	logic [31:0]        load_count_s1;

	// verifier state
	logic [DEPTH_W-1:0] depth_q;
	status_t            sticky_q;
	logic [1:0]         sticky_exp_q;
	logic [DEPTH_W-1:0] sticky_act_q;
	slot_t              top_q;
	logic [15:0]        db_count_q;

	step_ctl_t          ctl;
	logic [DEPTH_W-1:0] depth_next;
	status_t            sticky_next;
	logic [1:0]         exp_next;
	logic [DEPTH_W-1:0] act_next;
	slot_t              top_next;
	logic [DEPTH_W-1:0] rd_ptr;
	logic [DEPTH_W-1:0] wr_ptr;
	logic [SLOT_W-1:0]  rd_word;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// capture the op word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			opcode_s1     <= opcode;
			operand_s1    <= operand;
			load_kind_s1  <= load_kind;
			load_count_s1 <= load_count;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			db_count_q <= cfg_data;
		end
	end

	tsv_step #(
		.STACK_DEPTH(STACK_DEPTH),
		.DEPTH_W    (DEPTH_W)
	) u_step (
		.valid     (valid_s1),
		.opcode    (opcode_s1),
		.operand   (operand_s1),
		.load_kind (load_kind_s1),
		.load_count(load_count_s1),
		.depth     (depth_q),
		.sticky    (sticky_q),
		.db_count  (db_count_q),
		.ctl       (ctl),
		.depth_next(depth_next)
	);

	// stack body; the read port always holds the entry two below the top
	assign wr_ptr = depth_next - DEPTH_W'(1);
	assign rd_ptr = depth_next - DEPTH_W'(3);

	tsv_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ctl.wr_en),
		.wr_addr(wr_ptr[ADDR_W-1:0]),
		.wr_data(ctl.new_top),
		.rd_addr(rd_ptr[ADDR_W-1:0]),
		.rd_data(rd_word)
	);

	// next top, error and result values
	always_comb begin
		priority if (ctl.wr_en) begin
			top_next = ctl.new_top;
		end else if (ctl.top_from_mem) begin
			top_next = slot_t'(rd_word);
		end else begin
			top_next = top_q;
		end
	end

	assign sticky_next = ctl.set_err ? ctl.err_code : sticky_q;
	assign exp_next    = ctl.set_err ? ctl.err_exp : sticky_exp_q;
	assign act_next    = ctl.set_err ? (ctl.underflow ? depth_q : '0) : sticky_act_q;

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q      <= '0;
			sticky_q     <= ST_OK;
			sticky_exp_q <= '0;
			sticky_act_q <= '0;
		end else begin
			depth_q      <= depth_next;
			sticky_q     <= sticky_next;
			sticky_exp_q <= exp_next;
			sticky_act_q <= act_next;
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_next;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status         <= sticky_next;
			expected_depth <= exp_next;
			actual_depth   <= act_next;
			depth_after    <= depth_next;
			top_kind       <= (depth_next != '0) ? top_next.kind : '0;
			top_count      <= (depth_next != '0) ? top_next.count : '0;
		end
	end

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_sticky_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q != ST_OK |=> $stable(depth_q) && $stable(sticky_q))
		else $error("state changed after a sticky error");

	a_no_write_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> sticky_q == ST_OK && !ctl.set_err)
		else $error("stack write together with an error");

	a_done_follows_op: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("op word without a result");

	a_underflow_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_UNDERFLOW |-> expected_depth == '0 && actual_depth == '0)
		else $error("depth fields set without underflow");
`endif

endmodule
`default_nettype wire
